FILE: rtl/ira_pkg.sv
// Package for the integer to radix ASCII converter: shared constants, the
// command control struct, the back-end state type and the digit encoder.
// No dependencies.
`timescale 1ns / 1ps

package ira_pkg;

  localparam int BASE_W     = 5;
  localparam int CHAR_W     = 7;
  localparam int DIGIT_W    = 4;
  localparam int DIV_CHUNK  = 8;   // quotient bits resolved per divider cycle

  localparam logic [BASE_W-1:0]  RADIX_MIN = 5'd2;
  localparam logic [BASE_W-1:0]  RADIX_MAX = 5'd16;
  localparam logic [BASE_W-1:0]  RADIX_DEC = 5'd10;

  localparam logic [DIGIT_W-1:0] FIRST_LETTER_DIGIT = 4'd10;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_A     = 7'h41;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0]  CHAR_NONE  = 7'h00;

  typedef struct packed {
    logic [BASE_W-1:0] radix;
    logic              minus;
    logic              empty;
  } cmd_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_SHOW,
    ST_EMPTY
  } back_state_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    if (d >= FIRST_LETTER_DIGIT) begin
      return CHAR_A + CHAR_W'(d - FIRST_LETTER_DIGIT);
    end
    return CHAR_ZERO + CHAR_W'(d);
  endfunction

endpackage

FILE: rtl/ira_if.sv
// Handshake interfaces for the converter: input items and result characters.
// Depends on ira_pkg.
`timescale 1ns / 1ps

interface ira_in_if import ira_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic        [BASE_W-1:0]      base;

  modport source (output valid, value, base, input ready);
  modport sink   (input valid, value, base, output ready);
endinterface

interface ira_out_if import ira_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;
  logic              empty_res;

  modport source (output valid, character, last, empty_res, input ready);
  modport sink   (input valid, character, last, empty_res, output ready);
endinterface

FILE: rtl/ira_front.sv
// Front end: takes input items and classifies them into a radix, a magnitude
// and sign/empty flags for the command queue. Depends on ira_pkg, ira_if.
`timescale 1ns / 1ps

module ira_front import ira_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  ira_in_if.sink                 items,
  output logic                   cmd_valid,
  input  logic                   cmd_ready,
  output cmd_ctl_t               cmd_ctl,
  output logic [VALUE_WIDTH-1:0] cmd_mag
);

  logic [VALUE_WIDTH-1:0] raw;
  logic                   negative;
  logic                   base_ok;

  assign raw      = $unsigned(items.value);
  assign negative = raw[VALUE_WIDTH-1];
  assign base_ok  = (items.base >= RADIX_MIN) && (items.base <= RADIX_MAX);

  assign cmd_valid   = items.valid;
  assign items.ready = cmd_ready;

  always_comb begin
    if (base_ok) begin
      cmd_ctl.radix = items.base;
      cmd_ctl.minus = 1'b0;
      cmd_ctl.empty = negative;
      cmd_mag       = raw;
    end else begin
      // signed decimal fallback; the most negative value negates to itself
      cmd_ctl.radix = RADIX_DEC;
      cmd_ctl.minus = negative;
      cmd_ctl.empty = 1'b0;
      cmd_mag       = negative ? (~raw + 1'b1) : raw;
    end
  end

endmodule

FILE: rtl/ira_cmd_queue.sv
// Two-entry command queue between front and back ends.
// No dependencies beyond the standard library of types.
`timescale 1ns / 1ps

module ira_cmd_queue #(
  parameter int WIDTH = 39
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             push;
  logic             pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = slot[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: rtl/ira_back.sv
// Back end: iterative divider filling the digit store, then reverse read-out
// of the digits as ASCII transfers. Depends on ira_pkg, ira_if.
`timescale 1ns / 1ps

module ira_back import ira_pkg::*; #(
  parameter int DIGIT_STORE_DEPTH = 32,
  parameter int VALUE_WIDTH       = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  cmd_ctl_t               cmd_ctl,
  input  logic [VALUE_WIDTH-1:0] cmd_mag,
  ira_out_if.source              results
);

  localparam int STEPS = (VALUE_WIDTH + DIV_CHUNK - 1) / DIV_CHUNK;
  localparam int PW    = STEPS * DIV_CHUNK;
  localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int AW    = $clog2(DIGIT_STORE_DEPTH);
  localparam int CW    = $clog2(DIGIT_STORE_DEPTH + 1);

  back_state_t          state;
  back_state_t          state_next;
  logic [PW-1:0]        work;
  logic [PW-1:0]        work_next;
  logic [DIGIT_W-1:0]   rem;
  logic [DIGIT_W-1:0]   rem_next;
  logic [BASE_W-1:0]    radix;
  logic                 minus;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_dec;
  logic [SW-1:0]        step;
  logic [DIGIT_W-1:0]   rd_data;
  logic [DIGIT_W-1:0]   store [DIGIT_STORE_DEPTH];
  logic [DIV_CHUNK-1:0] chunk;
  logic [DIV_CHUNK-1:0] q;
  logic                 last_step;
  logic                 quot_zero;
  logic                 room;

  assign chunk     = work[PW-1 -: DIV_CHUNK];
  assign work_next = (work << DIV_CHUNK) | PW'(q);
  assign last_step = (step == SW'(STEPS - 1));
  assign quot_zero = (work_next == '0);
  assign count_dec = count - 1'b1;
  assign room      = (count < CW'(DIGIT_STORE_DEPTH));

  // restoring division, one quotient bit per inner step
  always_comb begin : div_chunk
    logic [DIGIT_W:0]   t;
    logic [DIGIT_W-1:0] r;
    r = rem;
    q = '0;
    for (int i = DIV_CHUNK - 1; i >= 0; i--) begin
      t = {r, chunk[i]};
      if (t >= radix) begin
        t    = t - radix;
        q[i] = 1'b1;
      end
      r = t[DIGIT_W-1:0];
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next        = state;
    cmd_ready         = 1'b0;
    results.valid     = 1'b0;
    results.character = CHAR_NONE;
    results.last      = 1'b0;
    results.empty_res = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          state_next = cmd_ctl.empty ? ST_EMPTY : ST_DIV;
        end
      end
      ST_DIV: begin
        if (last_step && quot_zero) begin
          state_next = minus ? ST_SIGN : ST_READ;
        end
      end
      ST_SIGN: begin
        results.valid     = 1'b1;
        results.character = CHAR_MINUS;
        if (results.ready) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_SHOW;
      end
      ST_SHOW: begin
        results.valid     = 1'b1;
        results.character = digit_char(rd_data);
        results.last      = (count == '0);
        if (results.ready) begin
          state_next = (count == '0) ? ST_IDLE : ST_READ;
        end
      end
      ST_EMPTY: begin
        results.valid     = 1'b1;
        results.last      = 1'b1;
        results.empty_res = 1'b1;
        if (results.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            work  <= PW'(cmd_mag);
            radix <= cmd_ctl.radix;
            minus <= cmd_ctl.minus;
            rem   <= '0;
            step  <= '0;
            count <= '0;
          end
        end
        ST_DIV: begin
          work <= work_next;
          if (last_step) begin
            step <= '0;
            rem  <= '0;
            if (room) begin
              count <= count + 1'b1;
            end
          end else begin
            step <= step + 1'b1;
            rem  <= rem_next;
          end
        end
        ST_READ: begin
          count <= count_dec;
        end
        default: begin
        end
      endcase
    end
  end

  // digit store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state == ST_DIV && last_step && room) begin
      store[count[AW-1:0]] <= rem_next;
    end
    if (state == ST_READ) begin
      rd_data <= store[count_dec[AW-1:0]];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DIGIT_STORE_DEPTH))
    else $error("digit count beyond store depth");

  a_sign_has_digits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SIGN || state == ST_READ) |-> count != '0)
    else $error("read-out started with no stored digit");

  a_fill_leaves_digit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && last_step && quot_zero) |=> count != '0)
    else $error("conversion finished with an empty store");

  a_show_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHOW && !results.ready) |=> state == ST_SHOW && $stable(rd_data))
    else $error("stalled digit transfer changed");

endmodule

FILE: rtl/integer_to_radix_ascii_core.sv
// Top level of the integer to radix ASCII converter: front end, command
// queue and back end. Depends on ira_pkg, ira_if, ira_front, ira_cmd_queue, ira_back.
//
//   channel   dir   payload                          transfer when
//   items     in    value[VALUE_WIDTH], base[5]      items.valid & items.ready
//   results   out   character[7], last, empty_res    results.valid & results.ready
//
// Items are taken one a cycle until the two-entry queue is full.
// Per item: a pop from the queue, then the divider fills the digit store,
// then each character follows a registered store read, after a minus sign
// for a negative value with an invalid base. A negative value with a valid
// base gives only an empty result. The default worst case is base 2, 31 digits.
// Reset is synchronous and clears queue and back-end control; a stalled
// result holds the back end while the front keeps filling the queue.
`timescale 1ns / 1ps

module integer_to_radix_ascii_core import ira_pkg::*; #(
  parameter int DIGIT_STORE_DEPTH = 32,
  parameter int VALUE_WIDTH       = 32
) (
  input logic       clk,
  input logic       rst,
  ira_in_if.sink    items,
  ira_out_if.source results
);

  localparam int QW = VALUE_WIDTH + $bits(cmd_ctl_t);

  logic                   f_valid;
  logic                   f_ready;
  cmd_ctl_t               f_ctl;
  logic [VALUE_WIDTH-1:0] f_mag;
  logic                   b_valid;
  logic                   b_ready;
  logic [QW-1:0]          b_data;
  cmd_ctl_t               b_ctl;
  logic [VALUE_WIDTH-1:0] b_mag;

  assign b_ctl = b_data[QW-1:VALUE_WIDTH];
  assign b_mag = b_data[VALUE_WIDTH-1:0];

  ira_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .items     (items),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd_ctl   (f_ctl),
    .cmd_mag   (f_mag)
  );

  ira_cmd_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_ctl, f_mag}),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  ira_back #(
    .DIGIT_STORE_DEPTH (DIGIT_STORE_DEPTH),
    .VALUE_WIDTH       (VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (b_valid),
    .cmd_ready (b_ready),
    .cmd_ctl   (b_ctl),
    .cmd_mag   (b_mag),
    .results   (results)
  );

endmodule

FILE: test/ira_text_checker.sv
// Checker for the integer to radix ASCII converter: predicts the character
// stream of every accepted item and compares each result transfer with it.
// Depends on ira_pkg and ira_if.
`timescale 1ns / 1ps

module ira_text_checker import ira_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  ira_in_if           items,
  ira_out_if          results,
  output int unsigned fail_count,
  output int unsigned chars_owed
);

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
    logic              empty_res;
  } text_char_t;

  text_char_t  expected_chars[$];
  int unsigned faults = 0;

  function automatic logic [CHAR_W-1:0] numeral_of(input logic [DIGIT_W-1:0] d);
    if (d >= 4'd10) begin
      return CHAR_A + CHAR_W'(d) - 7'd10;
    end
    return CHAR_ZERO + CHAR_W'(d);
  endfunction

  function automatic void predict_text(input logic [VALUE_WIDTH-1:0] raw,
                                       input logic [BASE_W-1:0] base_in);
    logic [VALUE_WIDTH-1:0] magnitude;
    logic [BASE_W-1:0]      radix;
    logic [DIGIT_W-1:0]     digits[$];
    logic                   negative;
    logic                   in_range;
    text_char_t             entry;
    negative = raw[VALUE_WIDTH-1];
    in_range = (base_in >= RADIX_MIN) && (base_in <= RADIX_MAX);
    if (in_range && negative) begin
      entry.character = CHAR_NONE;
      entry.last      = 1'b1;
      entry.empty_res = 1'b1;
      expected_chars.push_back(entry);
      return;
    end
    radix = in_range ? base_in : RADIX_DEC;
    magnitude = (negative && !in_range) ? -raw : raw;
    // remainders come out least significant first
    do begin
      digits.push_back(DIGIT_W'(magnitude % radix));
      magnitude = magnitude / radix;
    end while (magnitude != 0);
    if (negative && !in_range) begin
      entry.character = CHAR_MINUS;
      entry.last      = 1'b0;
      entry.empty_res = 1'b0;
      expected_chars.push_back(entry);
    end
    while (digits.size() > 0) begin
      entry.character = numeral_of(digits.pop_back());
      entry.last = (digits.size() == 0);
      entry.empty_res = 1'b0;
      expected_chars.push_back(entry);
    end
  endfunction

  function automatic void report_fault(input string what, input text_char_t want,
                                       input text_char_t got);
    faults++;
    if (faults <= 10) begin
      $display("%0t: %s: expected char %h last %b empty %b, got char %h last %b empty %b",
               $time, what, want.character, want.last, want.empty_res,
               got.character, got.last, got.empty_res);
    end
  endfunction

  always @(posedge clk) begin
    text_char_t got;
    text_char_t want;
    if (!rst) begin
      if (items.valid && items.ready) begin
        predict_text(items.value, items.base);
      end
      if (results.valid && results.ready) begin
        got = '{results.character, results.last, results.empty_res};
        if (expected_chars.size() == 0) begin
          report_fault("result with nothing outstanding", '0, got);
        end else begin
          want = expected_chars.pop_front();
          if (got !== want) begin
            report_fault("wrong result", want, got);
          end
        end
      end
    end
    fail_count <= faults;
    chars_owed <= expected_chars.size();
  end

endmodule

FILE: test/tb_integer_to_radix_ascii_core.sv
// Testbench top for the integer to radix ASCII converter: clock, reset,
// item and result traffic with idling and back-pressure, and the verdict.
// Depends on ira_pkg, ira_if, ira_text_checker and the converter RTL.
`timescale 1ns / 1ps

module tb_integer_to_radix_ascii_core import ira_pkg::*;;

  localparam int          HOLD_CYCLES = 400;
  localparam int unsigned LIMIT       = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned fail_count;
  int unsigned chars_owed;
  int unsigned cycle_count = 0;
  int          idle_odds = 0;
  bit          hold_pending = 1'b0;

  ira_in_if  items_ch ();
  ira_out_if results_ch ();

  integer_to_radix_ascii_core dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch)
  );

  ira_text_checker text_check (
    .clk        (clk),
    .rst        (rst),
    .items      (items_ch),
    .results    (results_ch),
    .fail_count (fail_count),
    .chars_owed (chars_owed)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [31:0] draw_value();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 300);
      1: return $urandom;
      2: return $urandom >> $urandom_range(0, 31);
      3: return -($urandom >> $urandom_range(1, 31));
      4: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'hFFFF_FFFF;
          3: return 32'h0000_0001;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom_range(0, 100000);
    endcase
  endfunction

  function automatic logic [BASE_W-1:0] draw_base();
    if ($urandom_range(0, 2) != 0) begin
      return BASE_W'($urandom_range(2, 16));
    end
    return BASE_W'($urandom_range(0, 31));
  endfunction

  task automatic send_item(input logic [31:0] v, input logic [BASE_W-1:0] b);
    if (idle_odds != 0 && $urandom_range(1, 100) <= idle_odds) begin
      items_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    items_ch.valid <= 1'b1;
    items_ch.value <= v;
    items_ch.base  <= b;
    @(posedge clk);
    while (!items_ch.ready) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_item(draw_value(), draw_base());
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (chars_owed != 0) @(posedge clk);
  endtask

  initial begin : result_sink
    results_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        results_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_odds != 0 && $urandom_range(1, 100) <= idle_odds) begin
        results_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      results_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : stimulus
    items_ch.valid <= 1'b0;
    items_ch.value <= '0;
    items_ch.base  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_odds = 25;
    send_item(32'd0, 5'd2);
    send_item(32'd0, 5'd16);
    send_item(32'd0, 5'd0);
    send_item(32'd0, 5'd1);
    send_item(32'h7FFF_FFFF, 5'd2);
    send_item(32'h7FFF_FFFF, 5'd16);
    send_item(32'h7FFF_FFFF, RADIX_DEC);
    send_item(32'h7FFF_FFFF, 5'd17);
    send_item(32'hFFFF_FFFF, 5'd2);
    send_item(32'h8000_0000, 5'd16);
    send_item(32'h8000_0000, 5'd0);
    send_item(32'h8000_0000, 5'd31);
    send_item(32'hFFFF_FFFF, 5'd1);
    send_item(-32'sd42, RADIX_DEC);
    send_item(-32'sd42, 5'd20);
    send_item(32'd255, 5'd16);
    send_item(32'h00AB_CDEF, 5'd16);
    send_item(32'd1, 5'd2);
    send_item(32'd42, 5'd3);
    send_item(32'd8, 5'd8);
    send_item(32'd1234567890, 5'd9);

    send_random(60);

    // long result stall: the queue fills and item transfers back up
    hold_pending = 1'b1;
    send_random(8);
    items_ch.valid <= 1'b0;
    wait_drained();

    idle_odds = 0;
    send_random(30);
    idle_odds = 30;
    send_random(30);
    idle_odds = 0;
    send_random(30);
    items_ch.valid <= 1'b0;

    wait_drained();
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/ira_pkg.sv
rtl/ira_if.sv
rtl/ira_front.sv
rtl/ira_cmd_queue.sv
rtl/ira_back.sv
rtl/integer_to_radix_ascii_core.sv
test/ira_text_checker.sv
test/tb_integer_to_radix_ascii_core.sv
